/* rtl/htw_pkg.sv */
// Shared definitions for the hierarchical timer wheel core.
// Holds default sizes, stream widths, operation codes and the sequencer state type.
// No dependencies.
package htw_pkg;

  localparam int ROOT_BITS_DEF   = 8;
  localparam int LEVEL_BITS_DEF  = 6;
  localparam int TIMER_COUNT_DEF = 16;

  localparam int IN_W  = 56;
  localparam int OUT_W = 8;

  localparam int MAX_FIRE = 16;
  localparam int CNT_W    = 5;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_ADV = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_T,
    ST_SET_CHK,
    ST_UNLINK,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_TK_CHK,
    ST_CAS_RD,
    ST_CAS_HEAD,
    ST_CAS_NEXT,
    ST_CAS_GET,
    ST_FIRE_RD,
    ST_FIRE_HEAD,
    ST_FIRE_NEXT,
    ST_FIRE_LINK,
    ST_DONE
  } state_t;

endpackage

/* rtl/hierarchical_timer_wheel_core.sv */
// Top level of the hierarchical timer wheel: sequencer, bucket and timer memories.
// Depends on htw_pkg.
//
// Five-level timer wheel for a pool of TIMER_COUNT timers. Each request is one set,
// delete or advance operation; it is taken only while the block is idle, and the next
// request waits until this one has finished its work. A set or a delete updates the
// linked bucket lists step by step through the bucket and timer memories. An advance
// walks the root bucket of every elapsed tick, fires its timers and cascades the wheel
// levels whose slot wraps, re-filing their timers, and waits while the result channel
// stalls. Each request ends with one result marked by tlast; an advance first
// delivers one result per expired timer, at most 16. After reset the bucket
// memories are cleared before the first request is taken.
module hierarchical_timer_wheel_core #(
  parameter int ROOT_BITS   = htw_pkg::ROOT_BITS_DEF,
  parameter int LEVEL_BITS  = htw_pkg::LEVEL_BITS_DEF,
  parameter int TIMER_COUNT = htw_pkg::TIMER_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // operation[1:0], timer_id[5:2], expire_time[37:6], tick_count[53:38], zero fill
  input  logic [htw_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // was_pending[0], fired_timer[4:1], zero fill
  output logic [htw_pkg::OUT_W-1:0] out_tdata,
  // fired_valid
  output logic                      out_tuser,
  output logic                      out_tlast
);
  import htw_pkg::*;

  localparam int ROOT_SIZE  = 1 << ROOT_BITS;
  localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
  localparam int BUCKETS    = ROOT_SIZE + 4 * LEVEL_SIZE;
  localparam int BW         = $clog2(BUCKETS);
  localparam int LW         = $clog2(TIMER_COUNT + 1);
  localparam int TIW        = $clog2(TIMER_COUNT);
  localparam int SH0        = ROOT_BITS;
  localparam int SH1        = ROOT_BITS + LEVEL_BITS;
  localparam int SH2        = ROOT_BITS + 2 * LEVEL_BITS;
  localparam int SH3        = ROOT_BITS + 3 * LEVEL_BITS;
  localparam logic [LW-1:0] NONE = '1;

  function automatic logic [LEVEL_BITS-1:0] level_slot(input logic [31:0] w,
                                                       input logic [1:0] l);
    logic [31:0] s;
    case (l)
      2'd0:    s = w >> SH0;
      2'd1:    s = w >> SH1;
      2'd2:    s = w >> SH2;
      default: s = w >> SH3;
    endcase
    return s[LEVEL_BITS-1:0];
  endfunction

  function automatic logic [BW-1:0] level_bucket(input logic [1:0] l,
                                                 input logic [LEVEL_BITS-1:0] slot);
    return BW'(ROOT_SIZE) + BW'({l, slot});
  endfunction

  function automatic logic [BW-1:0] pick_bucket(input logic [31:0] when,
                                                input logic [31:0] wheel);
    logic [31:0] span;
    logic [63:0] d64;
    span = when - wheel;
    d64  = {32'd0, span};
    if (d64 < (64'd1 << SH0)) begin
      return BW'(when[ROOT_BITS-1:0]);
    end else if (d64 < (64'd1 << SH1)) begin
      return level_bucket(2'd0, level_slot(when, 2'd0));
    end else if (d64 < (64'd1 << SH2)) begin
      return level_bucket(2'd1, level_slot(when, 2'd1));
    end else if (d64 < (64'd1 << SH3)) begin
      return level_bucket(2'd2, level_slot(when, 2'd2));
    end else if (span[31]) begin
      return BW'(wheel[ROOT_BITS-1:0]);
    end else begin
      return level_bucket(2'd3, level_slot(when, 2'd3));
    end
  endfunction

  logic [LW-1:0]  first_mem [BUCKETS];
  logic [LW-1:0]  final_mem [BUCKETS];
  logic [LW-1:0]  link_mem  [TIMER_COUNT];
  logic [LW-1:0]  back_mem  [TIMER_COUNT];
  logic [BW-1:0]  home_mem  [TIMER_COUNT];
  logic [31:0]    exp_mem   [TIMER_COUNT];

  logic [LW-1:0]  first_rd_r, final_rd_r, link_rd_r, back_rd_r;
  logic [BW-1:0]  home_rd_r;
  logic [31:0]    exp_rd_r;

  logic           first_we, final_we, link_we, back_we, home_we, exp_we;
  logic [BW-1:0]  first_wa, final_wa, first_ra, final_ra;
  logic [LW-1:0]  first_wd, final_wd, link_wd, back_wd;
  logic [TIW-1:0] link_wa, back_wa;

  state_t         state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [LW-1:0]  cur_t_r, cur_t_nxt, nxt_t_r, nxt_t_nxt;
  logic [31:0]    when_r, when_nxt, cur_time_r, cur_time_nxt, wheel_r, wheel_nxt;
  logic           pend_r, pend_nxt;
  logic [1:0]     lvl_r, lvl_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0]  bkt_r, bkt_nxt, clr_r, clr_nxt;
  logic [TIMER_COUNT-1:0] queued_r, queued_nxt;
  logic           out_valid_r, out_valid_nxt, out_pend_r, out_pend_nxt;
  logic           out_fv_r, out_fv_nxt, out_last_r, out_last_nxt;
  logic [3:0]     out_ft_r, out_ft_nxt;

  logic           accept, slot_free, id_ok;
  logic [1:0]     in_op;
  logic [3:0]     in_id;
  logic [31:0]    in_exp, diff;
  logic [15:0]    in_ticks;
  logic [TIW-1:0] in_tid, cur_tid;
  logic [BW-1:0]  pick_b, cas_b;

  assign in_op     = in_tdata[1:0];
  assign in_id     = in_tdata[5:2];
  assign in_exp    = in_tdata[37:6];
  assign in_ticks  = in_tdata[53:38];
  assign in_tid    = TIW'(in_id);
  assign cur_tid   = cur_t_r[TIW-1:0];
  assign id_ok     = 32'(in_id) < TIMER_COUNT;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign diff      = cur_time_r - wheel_r;
  assign pick_b    = pick_bucket(when_r, wheel_r);
  assign cas_b     = level_bucket(lvl_r, level_slot(wheel_r, lvl_r));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_ft_r, out_pend_r};
  assign out_tuser  = out_fv_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_wa] <= first_wd;
    end
    if (final_we) begin
      final_mem[final_wa] <= final_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (back_we) begin
      back_mem[back_wa] <= back_wd;
    end
    if (home_we) begin
      home_mem[cur_tid] <= bkt_r;
    end
    if (exp_we) begin
      exp_mem[cur_tid] <= when_r;
    end
    first_rd_r <= first_mem[first_ra];
    final_rd_r <= final_mem[final_ra];
    link_rd_r  <= link_mem[cur_tid];
    back_rd_r  <= back_mem[cur_tid];
    home_rd_r  <= home_mem[cur_tid];
    exp_rd_r   <= exp_mem[cur_tid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cur_time_r  <= '0;
      wheel_r     <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      lvl_r       <= '0;
      op_r        <= OP_SET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_time_r  <= cur_time_nxt;
      wheel_r     <= wheel_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      op_r        <= op_nxt;
    end
    cur_t_r    <= cur_t_nxt;
    nxt_t_r    <= nxt_t_nxt;
    when_r     <= when_nxt;
    pend_r     <= pend_nxt;
    bkt_r      <= bkt_nxt;
    out_pend_r <= out_pend_nxt;
    out_fv_r   <= out_fv_nxt;
    out_ft_r   <= out_ft_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_t_nxt     = cur_t_r;
    nxt_t_nxt     = nxt_t_r;
    when_nxt      = when_r;
    cur_time_nxt  = cur_time_r;
    wheel_nxt     = wheel_r;
    pend_nxt      = pend_r;
    lvl_nxt       = lvl_r;
    cnt_nxt       = cnt_r;
    bkt_nxt       = bkt_r;
    clr_nxt       = clr_r;
    queued_nxt    = queued_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_pend_nxt  = out_pend_r;
    out_fv_nxt    = out_fv_r;
    out_ft_nxt    = out_ft_r;
    out_last_nxt  = out_last_r;
    first_we = 1'b0;
    first_wa = bkt_r;
    first_wd = NONE;
    first_ra = bkt_r;
    final_we = 1'b0;
    final_wa = bkt_r;
    final_wd = NONE;
    final_ra = bkt_r;
    link_we  = 1'b0;
    link_wa  = cur_tid;
    link_wd  = NONE;
    back_we  = 1'b0;
    back_wa  = cur_tid;
    back_wd  = NONE;
    home_we  = 1'b0;
    exp_we   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        first_we = 1'b1;
        first_wa = clr_r;
        final_we = 1'b1;
        final_wa = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          cur_t_nxt = LW'(in_id);
          when_nxt  = in_exp;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          case (in_op)
            OP_SET: begin
              if (!id_ok) begin
                state_nxt = ST_DONE;
              end else if (queued_r[in_tid]) begin
                state_nxt = ST_RD_T;
              end else begin
                state_nxt = ST_ENQ_RD;
              end
            end
            OP_DEL: begin
              state_nxt = (id_ok && queued_r[in_tid]) ? ST_RD_T : ST_DONE;
            end
            OP_ADV: begin
              cur_time_nxt = cur_time_r + 32'(in_ticks);
              state_nxt    = ST_TK_CHK;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD_T: begin
        if (op_r == OP_SET) begin
          state_nxt = ST_SET_CHK;
        end else begin
          pend_nxt  = 1'b1;
          state_nxt = ST_UNLINK;
        end
      end
      ST_SET_CHK: begin
        pend_nxt  = 1'b1;
        state_nxt = (exp_rd_r == when_r) ? ST_DONE : ST_UNLINK;
      end
      ST_UNLINK: begin
        if (back_rd_r == NONE) begin
          first_we = 1'b1;
          first_wa = home_rd_r;
          first_wd = link_rd_r;
        end else begin
          link_we = 1'b1;
          link_wa = back_rd_r[TIW-1:0];
          link_wd = link_rd_r;
        end
        if (link_rd_r == NONE) begin
          final_we = 1'b1;
          final_wa = home_rd_r;
          final_wd = back_rd_r;
        end else begin
          back_we = 1'b1;
          back_wa = link_rd_r[TIW-1:0];
          back_wd = back_rd_r;
        end
        queued_nxt[cur_tid] = 1'b0;
        state_nxt = (op_r == OP_SET) ? ST_ENQ_RD : ST_DONE;
      end
      ST_ENQ_RD: begin
        bkt_nxt   = pick_b;
        final_ra  = pick_b;
        link_we   = 1'b1;
        exp_we    = 1'b1;
        state_nxt = ST_ENQ_WR;
      end
      ST_ENQ_WR: begin
        back_we  = 1'b1;
        back_wd  = final_rd_r;
        home_we  = 1'b1;
        final_we = 1'b1;
        final_wd = cur_t_r;
        if (final_rd_r == NONE) begin
          first_we = 1'b1;
          first_wd = cur_t_r;
        end else begin
          link_we = 1'b1;
          link_wa = final_rd_r[TIW-1:0];
          link_wd = cur_t_r;
        end
        queued_nxt[cur_tid] = 1'b1;
        if (op_r == OP_SET) begin
          state_nxt = ST_DONE;
        end else begin
          cur_t_nxt = nxt_t_r;
          state_nxt = ST_CAS_NEXT;
        end
      end
      ST_TK_CHK: begin
        if (diff[31]) begin
          state_nxt = ST_DONE;
        end else if (wheel_r[ROOT_BITS-1:0] == '0) begin
          lvl_nxt   = 2'd0;
          state_nxt = ST_CAS_RD;
        end else begin
          state_nxt = ST_FIRE_RD;
        end
      end
      ST_CAS_RD: begin
        first_ra  = cas_b;
        first_we  = 1'b1;
        first_wa  = cas_b;
        final_we  = 1'b1;
        final_wa  = cas_b;
        state_nxt = ST_CAS_HEAD;
      end
      ST_CAS_HEAD: begin
        cur_t_nxt = first_rd_r;
        state_nxt = ST_CAS_NEXT;
      end
      ST_CAS_NEXT: begin
        if (cur_t_r != NONE) begin
          state_nxt = ST_CAS_GET;
        end else if (level_slot(wheel_r, lvl_r) == '0 && lvl_r != 2'd3) begin
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = ST_CAS_RD;
        end else begin
          state_nxt = ST_FIRE_RD;
        end
      end
      ST_CAS_GET: begin
        nxt_t_nxt = link_rd_r;
        when_nxt  = exp_rd_r;
        state_nxt = ST_ENQ_RD;
      end
      ST_FIRE_RD: begin
        first_ra  = BW'(wheel_r[ROOT_BITS-1:0]);
        first_we  = 1'b1;
        first_wa  = BW'(wheel_r[ROOT_BITS-1:0]);
        final_we  = 1'b1;
        final_wa  = BW'(wheel_r[ROOT_BITS-1:0]);
        wheel_nxt = wheel_r + 32'd1;
        state_nxt = ST_FIRE_HEAD;
      end
      ST_FIRE_HEAD: begin
        cur_t_nxt = first_rd_r;
        state_nxt = ST_FIRE_NEXT;
      end
      ST_FIRE_NEXT: begin
        if (cur_t_r == NONE) begin
          state_nxt = ST_TK_CHK;
        end else if (cnt_r >= CNT_W'(MAX_FIRE)) begin
          queued_nxt[cur_tid] = 1'b0;
          state_nxt = ST_FIRE_LINK;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pend_nxt  = 1'b0;
          out_fv_nxt    = 1'b1;
          out_ft_nxt    = 4'(cur_t_r);
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r + 1'b1;
          queued_nxt[cur_tid] = 1'b0;
          state_nxt = ST_FIRE_LINK;
        end
      end
      ST_FIRE_LINK: begin
        cur_t_nxt = link_rd_r;
        state_nxt = ST_FIRE_NEXT;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pend_nxt  = pend_r;
          out_fv_nxt    = 1'b0;
          out_ft_nxt    = 4'd0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while a previous request was in progress");
  a_fire_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRE_NEXT && cur_t_r != NONE) |-> (32'(cur_t_r) < TIMER_COUNT))
    else $error("bucket walk reached a timer outside the pool");
  a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FIRE))
    else $error("too many expiry results for one request");
  a_last_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tuser)
    else $error("closing result flagged as an expiry");
`endif

endmodule

/* tb/sv/tb_hierarchical_timer_wheel_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for hierarchical_timer_wheel_core: streams set, delete,
// advance and invalid-opcode requests and checks every result against a timer wheel
// predictor. Depends on htw_pkg and the core RTL.
module tb_hierarchical_timer_wheel_core;
  import htw_pkg::*;

  localparam int NIL = -1;
  localparam logic [1:0] OP_BAD = 2'd3;

  typedef struct packed {
    logic [15:0] ticks;
    logic [31:0] when;
    logic [3:0]  id;
    logic [1:0]  op;
  } wheel_req_t;

  typedef struct packed {
    logic       pending;
    logic       fired;
    logic [3:0] timer;
    logic       last;
  } wheel_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  wheel_req_t req_q[$];
  wheel_res_t due_q[$];
  int errors;
  int offered;
  int taken;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  logic [31:0] gen_now;

  logic [31:0] now_t;
  logic [31:0] wheel_pos;
  logic [31:0] t_exp[16];
  bit t_busy[16];
  int t_nxt[16];
  int t_prv[16];
  int t_home[16];
  int b_head[512];
  int b_tail[512];

  hierarchical_timer_wheel_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_bucket(logic [31:0] w);
    logic [31:0] d;
    d = w - wheel_pos;
    if (d < 32'd256) return int'(w[7:0]);
    if (d < 32'd16384) return 256 + int'(w[13:8]);
    if (d < 32'd1048576) return 320 + int'(w[19:14]);
    if (d < 32'd67108864) return 384 + int'(w[25:20]);
    if (d >= 32'h8000_0000) return int'(wheel_pos[7:0]);
    return 448 + int'(w[31:26]);
  endfunction

  function automatic void file_timer(int t);
    int b;
    b = pick_bucket(t_exp[t]);
    t_nxt[t] = NIL;
    t_prv[t] = b_tail[b];
    if (b_tail[b] == NIL) b_head[b] = t;
    else t_nxt[b_tail[b]] = t;
    b_tail[b] = t;
    t_home[t] = b;
    t_busy[t] = 1'b1;
  endfunction

  function automatic void unfile_timer(int t);
    int p;
    int n;
    p = t_prv[t];
    n = t_nxt[t];
    if (p == NIL) b_head[t_home[t]] = n;
    else t_nxt[p] = n;
    if (n == NIL) b_tail[t_home[t]] = p;
    else t_prv[n] = p;
    t_busy[t] = 1'b0;
  endfunction

  function automatic int cascade(int level);
    int slot;
    int b;
    int t;
    int n;
    slot = int'((wheel_pos >> (8 + 6 * level)) & 32'd63);
    b = 256 + 64 * level + slot;
    t = b_head[b];
    b_head[b] = NIL;
    b_tail[b] = NIL;
    while (t != NIL) begin
      n = t_nxt[t];
      file_timer(t);
      t = n;
    end
    return slot;
  endfunction

  function automatic void predict_wheel(wheel_req_t r);
    logic pend;
    int fired;
    int slot;
    int t;
    int n;
    wheel_res_t res;
    pend = 1'b0;
    fired = 0;
    if (r.op == OP_SET) begin
      if (t_busy[r.id]) begin
        pend = 1'b1;
        if (t_exp[r.id] != r.when) begin
          unfile_timer(r.id);
          t_exp[r.id] = r.when;
          file_timer(r.id);
        end
      end else begin
        t_exp[r.id] = r.when;
        file_timer(r.id);
      end
    end else if (r.op == OP_DEL) begin
      if (t_busy[r.id]) begin
        pend = 1'b1;
        unfile_timer(r.id);
      end
    end else if (r.op == OP_ADV) begin
      now_t = now_t + r.ticks;
      while (!(now_t - wheel_pos >= 32'h8000_0000)) begin
        slot = int'(wheel_pos[7:0]);
        if (slot == 0 && cascade(0) == 0 && cascade(1) == 0 && cascade(2) == 0)
          void'(cascade(3));
        wheel_pos = wheel_pos + 1;
        t = b_head[slot];
        b_head[slot] = NIL;
        b_tail[slot] = NIL;
        while (t != NIL) begin
          n = t_nxt[t];
          t_busy[t] = 1'b0;
          if (fired < MAX_FIRE) begin
            res = '{1'b0, 1'b1, t[3:0], 1'b0};
            due_q.push_back(res);
            fired++;
          end
          t = n;
        end
      end
    end
    res = '{pend, 1'b0, 4'd0, 1'b1};
    due_q.push_back(res);
  endfunction

  task automatic report_mismatch(string what, wheel_res_t got, wheel_res_t want);
    $display("mismatch (%s): got p=%0b f=%0b id=%0d l=%0b want p=%0b f=%0b id=%0d l=%0b",
             what, got.pending, got.fired, got.timer, got.last,
             want.pending, want.fired, want.timer, want.last);
    errors++;
  endtask

  always @(posedge clk) begin
    wheel_res_t got;
    wheel_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_wheel(wheel_req_t'(in_tdata[53:0]));
        taken <= taken + 1;
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tuser, out_tdata[4:1], out_tlast};
        if (due_q.size() == 0) begin
          report_mismatch("unexpected", got, got);
        end else begin
          want = due_q.pop_front();
          if (got != want) report_mismatch("field", got, want);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || taken == offered) begin
      if (rst_n && req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= {2'b00, req_q.pop_front()};
        in_tvalid <= 1'b1;
        offered <= offered + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_req(logic [1:0] op, logic [3:0] id, logic [31:0] when,
                         logic [15:0] ticks);
    wheel_req_t r;
    r.op = op;
    r.id = id;
    r.when = when;
    r.ticks = ticks;
    if (op == OP_ADV) gen_now = gen_now + ticks;
    req_q.push_back(r);
  endtask

  task automatic add_random(int n);
    int k;
    int sel;
    logic [31:0] w;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        w = gen_now + $urandom_range(300);
        add_req(OP_SET, 4'($urandom), w, 16'($urandom));
      end else if (sel < 55) begin
        if ($urandom_range(1)) w = $urandom;
        else w = gen_now - $urandom_range(500);
        add_req(OP_SET, 4'($urandom), w, 16'($urandom));
      end else if (sel < 70) begin
        add_req(OP_DEL, 4'($urandom), $urandom, 16'($urandom));
      end else if (sel < 95) begin
        if ($urandom_range(9) < 8) add_req(OP_ADV, 4'($urandom), $urandom, 16'($urandom_range(40)));
        else add_req(OP_ADV, 4'($urandom), $urandom, 16'($urandom_range(700)));
      end else begin
        add_req(OP_BAD, 4'($urandom), $urandom, 16'($urandom));
      end
    end
  endtask

  task automatic drain_all();
    while (req_q.size() != 0 || in_tvalid || due_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    errors = 0;
    offered = 0;
    taken = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    gen_now = 0;
    now_t = 0;
    wheel_pos = 0;
    for (i = 0; i < 16; i++) begin
      t_busy[i] = 1'b0;
      t_exp[i] = 0;
      t_nxt[i] = NIL;
      t_prv[i] = NIL;
      t_home[i] = 0;
    end
    for (i = 0; i < 512; i++) begin
      b_head[i] = NIL;
      b_tail[i] = NIL;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_req(OP_SET, 4'd15, 32'd0, 16'd0);
    add_req(OP_SET, 4'd0, 32'd5, 16'hFFFF);
    add_req(OP_SET, 4'd0, 32'd5, 16'd0);
    add_req(OP_ADV, 4'd0, 32'd0, 16'd0);
    add_req(OP_SET, 4'd1, 32'd300, 16'd0);
    add_req(OP_SET, 4'd2, 32'd20000, 16'd0);
    add_req(OP_SET, 4'd3, 32'd2000000, 16'd0);
    add_req(OP_SET, 4'd4, 32'h7000_0000, 16'd0);
    add_req(OP_SET, 4'd5, 32'hFFFF_FFFF, 16'd0);
    add_req(OP_DEL, 4'd4, 32'hFFFF_FFFF, 16'd0);
    add_req(OP_DEL, 4'd4, 32'd0, 16'd0);
    add_req(OP_BAD, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(OP_ADV, 4'd0, 32'd0, 16'd10);
    for (i = 0; i < 16; i++) add_req(OP_SET, 4'(i), gen_now + 3, 16'd0);
    add_req(OP_ADV, 4'd0, 32'd0, 16'd5);
    add_req(OP_SET, 4'd6, gen_now + 30000, 16'd0);
    add_req(OP_ADV, 4'd0, 32'd0, 16'hFFFF);
    drain_all();

    add_random(12);
    drain_all();
    repeat (20) @(posedge clk);
    send_idle_pct = 66;
    add_random(12);
    drain_all();
    send_idle_pct = 0;
    recv_idle_pct = 66;
    add_random(12);
    drain_all();
    send_idle_pct = 35;
    recv_idle_pct = 35;
    add_random(12);
    drain_all();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = hold_req + 1;
    for (i = 0; i < 20; i++) add_req(OP_SET, 4'($urandom), $urandom, 16'd0);
    drain_all();

    repeat (100) @(posedge clk);
    if (errors == 0 && due_q.size() == 0) begin
      $display("hierarchical_timer_wheel_core test passed");
    end else begin
      $display("hierarchical_timer_wheel_core test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("hierarchical_timer_wheel_core test failed");
    $finish;
  end

endmodule
